// ===== design/hslrgb_pkg.sv =====
// Shared types and constants of the HSL to RGB color converter.
package hslrgb_pkg;

  localparam int HUE_W  = 12;
  localparam int CH_W   = 8;
  localparam int CN_W   = 16;  // chroma numerator, (255 - |2L - 255|) * S
  localparam int G_W    = 13;  // intermediate weight, 0..4096
  localparam int BASE_W = 17;  // 510 * L + 255
  localparam int PROD_W = 28;  // chroma numerator times weight
  localparam int SUM_W  = 29;  // component plus offset
  localparam int QIN_W  = 17;  // sum with the low 12 bits dropped

  localparam logic [CH_W-1:0] SATURATION_RESET = 8'd255;
  localparam logic [CH_W-1:0] LIGHTNESS_RESET  = 8'd166;

  typedef enum logic {
    REG_SATURATION = 1'b0,
    REG_LIGHTNESS  = 1'b1
  } reg_index_t;

  // Hue sectors of 60 degrees each; the order of chroma, intermediate and zero.
  typedef enum logic [2:0] {
    SEC_RED_YELLOW    = 3'd0,
    SEC_YELLOW_GREEN  = 3'd1,
    SEC_GREEN_CYAN    = 3'd2,
    SEC_CYAN_BLUE     = 3'd3,
    SEC_BLUE_MAGENTA  = 3'd4,
    SEC_MAGENTA_RED   = 3'd5
  } sector_t;

  typedef struct packed {
    logic [2:0]        sector;
    logic [G_W-1:0]    g;
    logic [CN_W-1:0]   cn;
    logic [BASE_W-1:0] base;
  } hue_stage_t;

  typedef struct packed {
    logic [2:0]        sector;
    logic [PROD_W-1:0] prod;
    logic [CN_W-1:0]   cn;
    logic [BASE_W-1:0] offs;
  } mul_stage_t;

  typedef struct packed {
    logic [QIN_W-1:0] red;
    logic [QIN_W-1:0] green;
    logic [QIN_W-1:0] blue;
  } mix_stage_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

endpackage

// ===== design/hslrgb_hue_stage.sv =====
// First stage: hue sector and weight, chroma numerator and offset base.
module hslrgb_hue_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic                          in_valid,
  input  logic [hslrgb_pkg::HUE_W-1:0]  hue,
  input  logic [hslrgb_pkg::CH_W-1:0]   saturation,
  input  logic [hslrgb_pkg::CH_W-1:0]   lightness,
  output logic                          valid,
  output hslrgb_pkg::hue_stage_t        data
);

  logic [14:0]                    t;
  logic [8:0]                     twol;
  logic [7:0]                     ldev;
  logic [7:0]                     span;
  hslrgb_pkg::hue_stage_t         data_next;

  always_comb begin
    t    = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
    twol = {lightness, 1'b0};
    if (twol >= 9'd255) begin
      ldev = 8'(twol - 9'd255);
    end else begin
      ldev = 8'(9'd255 - twol);
    end
    span = 8'd255 - ldev;
    data_next.sector = t[14:12];
    // Odd sectors run the intermediate component downward.
    if (t[12]) begin
      data_next.g = 13'd4096 - {1'b0, t[11:0]};
    end else begin
      data_next.g = {1'b0, t[11:0]};
    end
    data_next.cn   = {8'd0, span} * {8'd0, saturation};
    data_next.base = {lightness, 9'd0} - {8'd0, lightness, 1'b0} + 17'd255;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      data <= data_next;
    end
  end

endmodule

// ===== design/hslrgb_mul_stage.sv =====
// Second stage: intermediate product and lightness offset.
module hslrgb_mul_stage (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic                    in_valid,
  input  hslrgb_pkg::hue_stage_t  in_data,
  output logic                    valid,
  output hslrgb_pkg::mul_stage_t  data
);

  hslrgb_pkg::mul_stage_t data_next;

  always_comb begin
    data_next.sector = in_data.sector;
    data_next.prod   = hslrgb_pkg::PROD_W'(in_data.cn * in_data.g);
    data_next.cn     = in_data.cn;
    // Never negative: the base always covers the chroma numerator.
    data_next.offs   = in_data.base - {1'b0, in_data.cn};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      data <= data_next;
    end
  end

endmodule

// ===== design/hslrgb_mix_stage.sv =====
// Third stage: sector routing of the components and offset addition.
module hslrgb_mix_stage (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic                    in_valid,
  input  hslrgb_pkg::mul_stage_t  in_data,
  output logic                    valid,
  output hslrgb_pkg::mix_stage_t  data
);

  logic [hslrgb_pkg::PROD_W-1:0] cfull;
  logic [hslrgb_pkg::PROD_W-1:0] xpart;
  logic [hslrgb_pkg::PROD_W-1:0] offs;
  logic [hslrgb_pkg::PROD_W-1:0] r_c;
  logic [hslrgb_pkg::PROD_W-1:0] g_c;
  logic [hslrgb_pkg::PROD_W-1:0] b_c;
  logic [hslrgb_pkg::SUM_W-1:0]  r_sum;
  logic [hslrgb_pkg::SUM_W-1:0]  g_sum;
  logic [hslrgb_pkg::SUM_W-1:0]  b_sum;
  hslrgb_pkg::mix_stage_t        data_next;

  always_comb begin
    cfull = {in_data.cn, 12'd0};
    xpart = in_data.prod;
    offs  = {in_data.offs, 11'd0};
    unique case (hslrgb_pkg::sector_t'(in_data.sector))
      hslrgb_pkg::SEC_RED_YELLOW: begin
        r_c = cfull; g_c = xpart; b_c = '0;
      end
      hslrgb_pkg::SEC_YELLOW_GREEN: begin
        r_c = xpart; g_c = cfull; b_c = '0;
      end
      hslrgb_pkg::SEC_GREEN_CYAN: begin
        r_c = '0; g_c = cfull; b_c = xpart;
      end
      hslrgb_pkg::SEC_CYAN_BLUE: begin
        r_c = '0; g_c = xpart; b_c = cfull;
      end
      hslrgb_pkg::SEC_BLUE_MAGENTA: begin
        r_c = xpart; g_c = '0; b_c = cfull;
      end
      default: begin
        r_c = cfull; g_c = '0; b_c = xpart;
      end
    endcase
    r_sum = {1'b0, r_c} + {1'b0, offs};
    g_sum = {1'b0, g_c} + {1'b0, offs};
    b_sum = {1'b0, b_c} + {1'b0, offs};
    data_next.red   = r_sum[hslrgb_pkg::SUM_W-1:12];
    data_next.green = g_sum[hslrgb_pkg::SUM_W-1:12];
    data_next.blue  = b_sum[hslrgb_pkg::SUM_W-1:12];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      data <= data_next;
    end
  end

endmodule

// ===== design/hslrgb_div_stage.sv =====
// Fourth stage: division by 255 with clamp, the output register.
module hslrgb_div_stage (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic                    in_valid,
  input  hslrgb_pkg::mix_stage_t  in_data,
  output logic                    valid,
  output hslrgb_pkg::rgb_t        data
);

  // a = 256*q0 + lo = 255*q0 + (q0 + lo), so a/255 = q0 + (q0 + lo)/255.
  function automatic logic [hslrgb_pkg::CH_W-1:0] div255(
    input logic [hslrgb_pkg::QIN_W-1:0] a
  );
    logic [8:0] q0;
    logic [9:0] rem;
    logic [8:0] q;
    q0  = a[hslrgb_pkg::QIN_W-1:8];
    rem = {2'b00, a[7:0]} + {1'b0, q0};
    q   = q0 + {8'd0, rem >= 10'd255} + {8'd0, rem >= 10'd510};
    if (q > 9'd255) begin
      div255 = 8'd255;
    end else begin
      div255 = q[7:0];
    end
  endfunction

  hslrgb_pkg::rgb_t data_next;

  always_comb begin
    data_next.red   = div255(in_data.red);
    data_next.green = div255(in_data.green);
    data_next.blue  = div255(in_data.blue);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      data <= data_next;
    end
  end

endmodule

// ===== design/hsl_to_rgb_color_convert_core.sv =====
// Top level of the HSL to RGB color converter: ports, registers, stage chain.
//
// Use: each item on the s_ channel carries a 12-bit hue, a fraction of a full
// turn. Saturation and lightness are held in two registers written over the
// APB-style port (saturation at byte address 0, lightness at 4); they should
// only change while no item is in flight. Each input item gives exactly one
// item on the m_ channel holding 8-bit red, green and blue, rounded to nearest.
// The work runs in a four-stage pipeline: hue sector and chroma, one 16 by 13
// bit multiply, component routing with offset addition, then a division by
// 255 into the output register. One item is accepted every cycle when the sink
// keeps up. Every stage loads when it is empty or when the stage after it moves,
// so bubbles close up and the block keeps taking items while a result waits.
// When m_tready stays low the pipeline fills, and s_tready drops only once all
// four stages hold an item; nothing is dropped or repeated.
// Reset empties the pipeline and returns saturation to 255 and lightness to
// 166.
module hsl_to_rgb_color_convert_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] hue, [15:12] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [hslrgb_pkg::CH_W-1:0] saturation;
  logic [hslrgb_pkg::CH_W-1:0] lightness;
  logic                        cfg_write;

  logic                        v1, v2, v3;
  logic                        adv1, adv2, adv3, adv4;
  hslrgb_pkg::hue_stage_t      d1;
  hslrgb_pkg::mul_stage_t      d2;
  hslrgb_pkg::mix_stage_t      d3;
  hslrgb_pkg::rgb_t            d4;

  // Configuration registers. Only paddr[2] selects; the low bits are ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation <= hslrgb_pkg::SATURATION_RESET;
      lightness  <= hslrgb_pkg::LIGHTNESS_RESET;
    end else if (cfg_write) begin
      unique case (hslrgb_pkg::reg_index_t'(paddr[2]))
        hslrgb_pkg::REG_SATURATION: saturation <= pwdata[7:0];
        hslrgb_pkg::REG_LIGHTNESS:  lightness  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (hslrgb_pkg::reg_index_t'(paddr[2]))
      hslrgb_pkg::REG_SATURATION: prdata = {24'd0, saturation};
      hslrgb_pkg::REG_LIGHTNESS:  prdata = {24'd0, lightness};
      default:                    prdata = '0;
    endcase
  end

  // A stage loads when it is empty or when its successor takes its item.
  assign adv4     = !m_tvalid || m_tready;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign s_tready = adv1;

  hslrgb_hue_stage u_hue (
    .clk        (clk),
    .rst        (rst),
    .load       (adv1),
    .in_valid   (s_tvalid),
    .hue        (s_tdata[11:0]),
    .saturation (saturation),
    .lightness  (lightness),
    .valid      (v1),
    .data       (d1)
  );

  hslrgb_mul_stage u_mul (
    .clk      (clk),
    .rst      (rst),
    .load     (adv2),
    .in_valid (v1),
    .in_data  (d1),
    .valid    (v2),
    .data     (d2)
  );

  hslrgb_mix_stage u_mix (
    .clk      (clk),
    .rst      (rst),
    .load     (adv3),
    .in_valid (v2),
    .in_data  (d2),
    .valid    (v3),
    .data     (d3)
  );

  hslrgb_div_stage u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (adv4),
    .in_valid (v3),
    .in_data  (d3),
    .valid    (m_tvalid),
    .data     (d4)
  );

  assign m_tdata = {d4.blue, d4.green, d4.red};

  // An accepted item always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v1)
    else $error("accepted item did not enter the first stage");

  // Input back-pressure only once every stage is occupied.
  a_full_before_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> v1 && v2 && v3 && m_tvalid)
    else $error("input stalled while the pipeline had a bubble");

  // An item moving out of the third stage shows up on the output.
  a_last_hop: assert property (@(posedge clk) disable iff (rst)
    v3 && adv4 |=> m_tvalid)
    else $error("item lost between the last two stages");

  // The first stage never drops a held item while it cannot move on.
  a_hold_first: assert property (@(posedge clk) disable iff (rst)
    v1 && !adv2 |=> v1 && $stable(d1))
    else $error("first stage lost or changed a stalled item");

endmodule

// ===== bench/hsl_to_rgb_color_convert_core_tb.sv =====
// Self-checking testbench of the HSL to RGB color converter core.
`timescale 1ns / 1ps

module hsl_to_rgb_color_convert_core_tb;

  // The watchdog ends the run after this many cycles in which nothing moved on
  // either stream or on the register port. Gaps and stalls are short, so a
  // correct run never comes near it.
  localparam int QUIET_LIMIT = 2000;
  // The pipeline is four stages deep; a little margin is added.
  localparam int PIPE_LATENCY = 6;
  localparam int ITEMS_PER_PHASE = 54;
  localparam int NUM_PHASES = 12;
  localparam int NUM_FIXED = 8;
  localparam int CALM_PHASE = 3;
  localparam int IDLE_PERCENT = 28;
  localparam int MAX_REPORTS = 10;

  // Sector edges sit where 6 * hue crosses a multiple of 4096.
  localparam logic [11:0] EDGE_HUES [19] = '{
    12'd0, 12'd1, 12'd682, 12'd683, 12'd1365, 12'd1366, 12'd2047, 12'd2048,
    12'd2730, 12'd2731, 12'd3413, 12'd3414, 12'd4095, 12'd341, 12'd1024,
    12'd2389, 12'd3755, 12'hAAA, 12'h555
  };
  // Saturation and lightness pairs: the extremes of both, the fold of the
  // chroma curve at 127/128, the smallest nonzero values and a few in between.
  localparam logic [7:0] SAT_TAB [NUM_FIXED] = '{
    8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd1, 8'd128, 8'd37
  };
  localparam logic [7:0] LIGHT_TAB [NUM_FIXED] = '{
    8'd128, 8'd0, 8'd255, 8'd127, 8'd128, 8'd1, 8'd64, 8'd200
  };

  // Holds the expected colors in order and the converter's register copy.
  class rgb_scoreboard;
    logic [hslrgb_pkg::CH_W-1:0] saturation = hslrgb_pkg::SATURATION_RESET;
    logic [hslrgb_pkg::CH_W-1:0] lightness  = hslrgb_pkg::LIGHTNESS_RESET;
    hslrgb_pkg::rgb_t expected_rgb [$];
    int errors;
    int checked;

    function automatic logic [hslrgb_pkg::CH_W-1:0] to_byte(longint unsigned v);
      longint unsigned q;
      q = (v + 64'd1044480) / 64'd2088960;  // round half up, divide by 255*8192
      return (q > 255) ? 8'hFF : q[hslrgb_pkg::CH_W-1:0];
    endfunction

    // All terms share the unit 1/(65025*8192) so the sums stay exact.
    function automatic hslrgb_pkg::rgb_t predict_rgb(logic [hslrgb_pkg::HUE_W-1:0] hue);
      longint unsigned twol, ldev, cn, t, f, g, cu, xu, lpart, mu, r, gr, b;
      hslrgb_pkg::sector_t sec;
      hslrgb_pkg::rgb_t rgb;
      twol  = 2 * lightness;
      ldev  = (twol >= 255) ? twol - 255 : 255 - twol;
      cn    = (255 - ldev) * saturation;
      t     = hue * 6;
      sec   = hslrgb_pkg::sector_t'(t >> hslrgb_pkg::HUE_W);
      f     = t & 64'hFFF;
      g     = sec[0] ? 4096 - f : f;
      cu    = cn * 8192;
      xu    = cn * g * 2;
      lpart = 510 * lightness;
      mu    = (lpart >= cn) ? 4096 * (lpart - cn) : 0;
      case (sec)
        hslrgb_pkg::SEC_RED_YELLOW: begin
          r = cu; gr = xu; b = 0;
        end
        hslrgb_pkg::SEC_YELLOW_GREEN: begin
          r = xu; gr = cu; b = 0;
        end
        hslrgb_pkg::SEC_GREEN_CYAN: begin
          r = 0; gr = cu; b = xu;
        end
        hslrgb_pkg::SEC_CYAN_BLUE: begin
          r = 0; gr = xu; b = cu;
        end
        hslrgb_pkg::SEC_BLUE_MAGENTA: begin
          r = xu; gr = 0; b = cu;
        end
        default: begin
          r = cu; gr = 0; b = xu;
        end
      endcase
      rgb.red   = to_byte(r + mu);
      rgb.green = to_byte(gr + mu);
      rgb.blue  = to_byte(b + mu);
      return rgb;
    endfunction

    function void set_reg(hslrgb_pkg::reg_index_t idx, logic [31:0] word);
      if (idx == hslrgb_pkg::REG_SATURATION) saturation = word[hslrgb_pkg::CH_W-1:0];
      else lightness = word[hslrgb_pkg::CH_W-1:0];
    endfunction

    function void note_hue(logic [hslrgb_pkg::HUE_W-1:0] hue);
      expected_rgb.push_back(predict_rgb(hue));
    endfunction

    function void fail(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("%t mismatch: %s", $realtime, what);
    endfunction

    function void check_rgb(logic [23:0] data);
      hslrgb_pkg::rgb_t got, want;
      got = hslrgb_pkg::rgb_t'(data);
      if (expected_rgb.size() == 0) begin
        fail($sformatf("color r=%0d g=%0d b=%0d with no hue waiting",
                       got.red, got.green, got.blue));
        return;
      end
      want = expected_rgb.pop_front();
      checked++;
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
        fail($sformatf("S=%0d L=%0d expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       saturation, lightness, want.red, want.green, want.blue,
                       got.red, got.green, got.blue));
    endfunction

    function void check_reg(hslrgb_pkg::reg_index_t idx, logic [31:0] data);
      logic [hslrgb_pkg::CH_W-1:0] want;
      want = (idx == hslrgb_pkg::REG_SATURATION) ? saturation : lightness;
      if (data[hslrgb_pkg::CH_W-1:0] !== want)
        fail($sformatf("register %s read %0d, expected %0d", idx.name(),
                       data[hslrgb_pkg::CH_W-1:0], want));
    endfunction

    function int pending();
      return expected_rgb.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rgb_scoreboard sb = new;
  bit calm;           // when set, neither side idles
  int hues_accepted;
  int settings_run;
  int quiet_cycles;

  hsl_to_rgb_color_convert_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // The sink stalls at random, except during the calm phase.
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Monitor. Every input of the block changes only by nonblocking assignment,
  // so the values read here are those that were present at this edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_hue(s_tdata[hslrgb_pkg::HUE_W-1:0]);
        hues_accepted++;
      end
      if (m_tvalid && m_tready) sb.check_rgb(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("Watchdog: no progress for %0d cycles, %0d colors still expected.",
             QUIET_LIMIT, sb.pending());
    $display("TB_ERROR");
    $finish;
  end

  // One register write: setup cycle, then access cycle until pready. The upper
  // data bits are random because the block must ignore them.
  task automatic write_reg(hslrgb_pkg::reg_index_t idx,
                           logic [hslrgb_pkg::CH_W-1:0] value);
    logic [31:0] word;
    word = $urandom();
    word[hslrgb_pkg::CH_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, word);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_reg(hslrgb_pkg::reg_index_t idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_reg(idx, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one hue, after an optional random gap, and holds it until taken.
  // Valid stays high from one item to the next when there is no gap.
  task automatic send_hue(logic [hslrgb_pkg::HUE_W-1:0] hue);
    int gap;
    if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      gap = $urandom_range(4, 1);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, hue};
    do @(posedge clk); while (!s_tready);
  endtask

  // Mostly uniform hues; about one in five lands next to a sector edge.
  function automatic logic [hslrgb_pkg::HUE_W-1:0] pick_hue();
    int edge_hue;
    if ($urandom_range(99) < 80) return hslrgb_pkg::HUE_W'($urandom_range(4095));
    edge_hue = (4096 * $urandom_range(6) + 5) / 6 + $urandom_range(4) - 2;
    if (edge_hue < 0) edge_hue = 0;
    if (edge_hue > 4095) edge_hue = 4095;
    return hslrgb_pkg::HUE_W'(edge_hue);
  endfunction

  // Waits until every color has come back, then lets the pipeline settle
  // before the registers may be touched.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  initial begin
    logic [hslrgb_pkg::CH_W-1:0] sat, light;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values first, then every sector edge and both ends of the hue
    // range under the reset saturation and lightness.
    read_reg(hslrgb_pkg::REG_SATURATION);
    read_reg(hslrgb_pkg::REG_LIGHTNESS);
    settings_run = 1;
    foreach (EDGE_HUES[i]) send_hue(EDGE_HUES[i]);
    drain();

    // Random phases, each under its own setting. The fixed settings come
    // first; one phase runs with neither side idling.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase < NUM_FIXED) begin
        sat   = SAT_TAB[phase];
        light = LIGHT_TAB[phase];
      end else begin
        sat   = hslrgb_pkg::CH_W'($urandom_range(255));
        light = hslrgb_pkg::CH_W'($urandom_range(255));
      end
      write_reg(hslrgb_pkg::REG_SATURATION, sat);
      write_reg(hslrgb_pkg::REG_LIGHTNESS, light);
      read_reg(hslrgb_pkg::REG_SATURATION);
      read_reg(hslrgb_pkg::REG_LIGHTNESS);
      settings_run++;
      calm = (phase == CALM_PHASE);
      repeat (ITEMS_PER_PHASE) send_hue(pick_hue());
      drain();
      calm = 1'b0;
    end

    $display("Converted %0d hues under %0d saturation and lightness settings;",
             hues_accepted, settings_run);
    $display("%0d colors compared, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
